// ===== sv/hpt_pkg.sv =====
package hpt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CW = 32;
	localparam int NREG = 8;
	localparam int IDXW = $clog2(NREG);
	localparam int REGW = 2 * CW;
	// exact sum of four products
	localparam int SUMW = 2 * CW + 2;
	// floored transformed coordinate
	localparam int TW = SUMW - FRAC_BITS;
	// dividend magnitude shifted up by the fraction bits
	localparam int NW = TW + FRAC_BITS;
	// quotient bits kept; anything at or above 2^QB saturates
	localparam int QB = CW + 1;
	localparam int DW = NW + QB;
	localparam int FIFO_DEPTH = 4;
	localparam int FAW = $clog2(FIFO_DEPTH);

	localparam logic [REGW-1:0] ROW3_23_RESET = REGW'(1) << (CW + FRAC_BITS);
	localparam logic [CW-1:0] MAX_POS = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] MIN_NEG = {1'b1, {(CW-1){1'b0}}};

	typedef logic signed [TW-1:0] tval_t;

	typedef struct packed {
		tval_t w;
		tval_t z;
		tval_t y;
		tval_t x;
	} tvec_t;

endpackage

// ===== sv/hpt_fifo.sv =====
module hpt_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hpt_pkg::tvec_t wdata,
	output logic          full,
	input  logic          pop,
	output hpt_pkg::tvec_t rdata,
	output logic          empty
);

	hpt_pkg::tvec_t mem_q [hpt_pkg::FIFO_DEPTH];
	logic [hpt_pkg::FAW-1:0] wptr_q, rptr_q;
	logic [hpt_pkg::FAW:0] cnt_q;

	assign full  = (cnt_q == (hpt_pkg::FAW+1)'(hpt_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

endmodule

// ===== sv/hpt_front.sv =====
module hpt_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [hpt_pkg::IDXW-1:0]    cfg_index,
	input  logic [hpt_pkg::REGW-1:0]    cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [4*hpt_pkg::CW-1:0]    in_data,
	output logic                        push,
	output hpt_pkg::tvec_t              push_data,
	input  logic                        fifo_full
);

	logic [hpt_pkg::REGW-1:0] regs_q [hpt_pkg::NREG];
	logic signed [hpt_pkg::CW-1:0] m_w [4][4];
	logic signed [hpt_pkg::CW-1:0] p_w [4];
	logic signed [2*hpt_pkg::CW-1:0] prod_s1 [4][4];
	logic v_s1, v_s2;
	hpt_pkg::tval_t t_s2 [4];
	logic signed [hpt_pkg::SUMW-1:0] sum [4];
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hpt_pkg::NREG; i++)
				regs_q[i] <= (i == hpt_pkg::NREG-1) ? hpt_pkg::ROW3_23_RESET : '0;
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	for (genvar r = 0; r < 4; r++) begin : g_row
		assign p_w[r] = signed'(in_data[r*hpt_pkg::CW +: hpt_pkg::CW]);
		for (genvar c = 0; c < 4; c++) begin : g_col
			assign m_w[r][c] = signed'(regs_q[r*2 + c/2][(c%2)*hpt_pkg::CW +: hpt_pkg::CW]);
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			sum[r] = '0;
			for (int c = 0; c < 4; c++)
				sum[r] = sum[r] + hpt_pkg::SUMW'(prod_s1[r][c]);
		end
	end

	// stage 2 waits only when it holds a word the queue cannot take
	assign en       = !v_s2 || !fifo_full;
	assign in_ready = en;
	assign push     = v_s2 && !fifo_full;
	assign push_data = '{w: t_s2[3], z: t_s2[2], y: t_s2[1], x: t_s2[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++)
					prod_s1[r][c] <= m_w[r][c] * p_w[c];
				// arithmetic shift gives the floor
				t_s2[r] <= signed'(sum[r][hpt_pkg::SUMW-1:hpt_pkg::FRAC_BITS]);
			end
		end
	end

endmodule

// ===== sv/hpt_back.sv =====
module hpt_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fifo_empty,
	input  hpt_pkg::tvec_t           fifo_data,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [hpt_pkg::CW-1:0]   x_out,
	output logic [hpt_pkg::CW-1:0]   y_out,
	output logic [hpt_pkg::CW-1:0]   z_out,
	output logic                     div_by_zero,
	output logic                     overflow
);

	localparam int S = hpt_pkg::QB;

	logic en;
	hpt_pkg::tval_t tn [3];
	logic [hpt_pkg::TW-1:0] dm_in;
	logic [hpt_pkg::TW-1:0] nm_in [3];

	logic                    v_q   [S+1];
	logic                    dz_q  [S+1];
	logic [hpt_pkg::TW-1:0]  dm_q  [S+1];
	logic [hpt_pkg::NW-1:0]  rem_q [S+1][3];
	logic [hpt_pkg::QB-1:0]  quo_q [S+1][3];
	logic                    neg_q [S+1][3];
	logic                    pov_q [S+1][3];
	logic                    sgn_q [S+1][3];
	logic                    nz_q  [S+1][3];

	logic                    out_v_q;
	logic [hpt_pkg::CW-1:0]  res_q [3];
	logic                    dz_out_q, ovf_out_q;
	logic [hpt_pkg::CW-1:0]  res [3];
	logic [2:0]              sat;

	assign en  = !out_v_q || out_ready;
	assign pop = en && !fifo_empty;

	assign tn[0] = fifo_data.x;
	assign tn[1] = fifo_data.y;
	assign tn[2] = fifo_data.z;
	assign dm_in = fifo_data.w[hpt_pkg::TW-1] ? -fifo_data.w : fifo_data.w;
	for (genvar l = 0; l < 3; l++) begin : g_mag
		assign nm_in[l] = tn[l][hpt_pkg::TW-1] ? -tn[l] : tn[l];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= S; i++)
				v_q[i] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_q[0] <= !fifo_empty;
			for (int i = 0; i < S; i++)
				v_q[i+1] <= v_q[i];
			out_v_q <= v_q[S];
		end
	end

	// entry stage: magnitudes, signs and the early overflow test
	always_ff @(posedge clk) begin
		if (en) begin
			dz_q[0] <= (fifo_data.w == '0);
			dm_q[0] <= dm_in;
			for (int l = 0; l < 3; l++) begin
				rem_q[0][l] <= {nm_in[l], {hpt_pkg::FRAC_BITS{1'b0}}};
				quo_q[0][l] <= '0;
				neg_q[0][l] <= tn[l][hpt_pkg::TW-1] ^ fifo_data.w[hpt_pkg::TW-1];
				pov_q[0][l] <= hpt_pkg::DW'({nm_in[l], {hpt_pkg::FRAC_BITS{1'b0}}})
					>= (hpt_pkg::DW'(dm_in) << hpt_pkg::QB);
				sgn_q[0][l] <= tn[l][hpt_pkg::TW-1];
				nz_q[0][l]  <= (tn[l] != '0);
			end
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar i = 0; i < S; i++) begin : g_stage
		localparam int K = S - 1 - i;
		always_ff @(posedge clk) begin
			if (en) begin
				dz_q[i+1] <= dz_q[i];
				dm_q[i+1] <= dm_q[i];
				for (int l = 0; l < 3; l++) begin
					neg_q[i+1][l] <= neg_q[i][l];
					pov_q[i+1][l] <= pov_q[i][l];
					sgn_q[i+1][l] <= sgn_q[i][l];
					nz_q[i+1][l]  <= nz_q[i][l];
					if (hpt_pkg::DW'(rem_q[i][l]) >= (hpt_pkg::DW'(dm_q[i]) << K)) begin
						rem_q[i+1][l] <= hpt_pkg::NW'(hpt_pkg::DW'(rem_q[i][l])
							- (hpt_pkg::DW'(dm_q[i]) << K));
						quo_q[i+1][l] <= quo_q[i][l] | (hpt_pkg::QB'(1) << K);
					end else begin
						rem_q[i+1][l] <= rem_q[i][l];
						quo_q[i+1][l] <= quo_q[i][l];
					end
				end
			end
		end
	end

	always_comb begin
		logic [hpt_pkg::QB-1:0] lim;
		logic [hpt_pkg::QB-1:0] q;
		for (int l = 0; l < 3; l++) begin
			lim = neg_q[S][l] ? hpt_pkg::QB'(hpt_pkg::MIN_NEG)
				: hpt_pkg::QB'(hpt_pkg::MAX_POS);
			sat[l] = pov_q[S][l] || (quo_q[S][l] > lim);
			q = sat[l] ? lim : quo_q[S][l];
			if (dz_q[S])
				res[l] = !nz_q[S][l] ? '0 : (sgn_q[S][l] ? hpt_pkg::MIN_NEG : hpt_pkg::MAX_POS);
			else
				res[l] = neg_q[S][l] ? hpt_pkg::CW'(-q) : hpt_pkg::CW'(q);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++)
				res_q[l] <= res[l];
			dz_out_q  <= dz_q[S];
			ovf_out_q <= !dz_q[S] && (sat != '0);
		end
	end

	assign out_valid   = out_v_q;
	assign x_out       = res_q[0];
	assign y_out       = res_q[1];
	assign z_out       = res_q[2];
	assign div_by_zero = dz_out_q;
	assign overflow    = ovf_out_q;

endmodule

// ===== sv/homogeneous_point_transform.sv =====
// channel   dir  handshake         payload
// s_axis    in   tvalid/tready     tdata: x_in, y_in, z_in, w_in
// m_axis    out  tvalid/tready     tdata: x_out, y_out, z_out; tuser: div_by_zero, overflow
// cfg       in   cfg_we            cfg_index, cfg_data
//
// one word per cycle sustained while m_tready holds; the path runs through multiply and row sum,
// the queue, and one quotient bit per stage over 33 stages plus entry and saturation
// arst_n clears valids and loads the identity-w matrix entry
// a stall at m_axis holds the divider pipe; the 4-word queue lets the front keep going
module homogeneous_point_transform (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [hpt_pkg::IDXW-1:0]     cfg_index,
	input  logic [hpt_pkg::REGW-1:0]     cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [4*hpt_pkg::CW-1:0]     s_tdata,   // x_in, y_in, z_in, w_in
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [3*hpt_pkg::CW-1:0]     m_tdata,   // x_out, y_out, z_out
	output logic [1:0]                   m_tuser    // div_by_zero, overflow
);

	logic push, fifo_full, pop, fifo_empty;
	hpt_pkg::tvec_t push_data, pop_data;
	logic [hpt_pkg::CW-1:0] x_out, y_out, z_out;
	logic div_by_zero, overflow;

	hpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.push      (push),
		.push_data (push_data),
		.fifo_full (fifo_full)
	);

	hpt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (fifo_full),
		.pop    (pop),
		.rdata  (pop_data),
		.empty  (fifo_empty)
	);

	hpt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_empty  (fifo_empty),
		.fifo_data   (pop_data),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.x_out       (x_out),
		.y_out       (y_out),
		.z_out       (z_out),
		.div_by_zero (div_by_zero),
		.overflow    (overflow)
	);

	assign m_tdata = {z_out, y_out, x_out};
	assign m_tuser = {overflow, div_by_zero};

endmodule

// ===== verif/tb.sv =====
module tb;

	typedef struct {
		logic [31:0] x, y, z;
		logic dz, ovf;
	} point_res_t;

	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [hpt_pkg::IDXW-1:0] cfg_index = '0;
	logic [hpt_pkg::REGW-1:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [4*hpt_pkg::CW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [95:0] m_tdata;
	logic [1:0] m_tuser;

	homogeneous_point_transform uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	logic [hpt_pkg::REGW-1:0] matrix [hpt_pkg::NREG];
	logic [4*hpt_pkg::CW-1:0] pending_points [$];
	point_res_t expected_points [$];
	int errors = 0;
	int checked = 0;
	int n_dz = 0;
	int n_ovf = 0;
	int idle_cycles = 0;
	bit stream_on = 0;

	function automatic logic signed [127:0] mat_entry(int r, int c);
		logic [hpt_pkg::REGW-1:0] reg_v;
		reg_v = matrix[r*2 + c/2];
		return (c % 2) ? 128'(signed'(reg_v[63:32])) : 128'(signed'(reg_v[31:0]));
	endfunction

	function automatic logic [31:0] sat_div(logic signed [127:0] n, logic signed [127:0] d,
			ref logic ovf);
		logic [127:0] nm, dm, q, lim;
		logic neg;
		nm = n < 0 ? -n : n;
		dm = d < 0 ? -d : d;
		neg = (n < 0) != (d < 0);
		q = (nm << hpt_pkg::FRAC_BITS) / dm;
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (q > lim) begin
			ovf = 1;
			q = lim;
		end
		if (neg)
			q = -q;
		return q[31:0];
	endfunction

	function automatic point_res_t transform_point(logic [4*hpt_pkg::CW-1:0] p);
		logic signed [127:0] t [4];
		logic signed [127:0] acc;
		logic ovf;
		point_res_t r;
		logic [31:0] o [3];
		for (int i = 0; i < 4; i++) begin
			acc = 0;
			for (int c = 0; c < 4; c++)
				acc += mat_entry(i, c) * 128'(signed'(p[c*32 +: 32]));
			t[i] = acc >>> hpt_pkg::FRAC_BITS;
		end
		ovf = 0;
		if (t[3] == 0) begin
			for (int i = 0; i < 3; i++)
				o[i] = t[i] > 0 ? hpt_pkg::MAX_POS : (t[i] < 0 ? hpt_pkg::MIN_NEG : '0);
			r.dz = 1;
		end else begin
			for (int i = 0; i < 3; i++)
				o[i] = sat_div(t[i], t[3], ovf);
			r.dz = 0;
		end
		r.x = o[0];
		r.y = o[1];
		r.z = o[2];
		r.ovf = ovf;
		return r;
	endfunction

	// driver: bursts and gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_points.push_back(transform_point(s_tdata));
			void'(pending_points.pop_front());
		end
		if (!stream_on || (s_tvalid && !s_tready)) begin
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			s_tvalid <= 0;
		end else if (pending_points.size() > 0) begin
			s_tvalid <= 1;
			s_tdata <= pending_points[0];
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 20);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			end else
				burst_left <= burst_left - 1;
		end else
			s_tvalid <= 0;
	end

	// receiver stall pattern
	int rx_phase = 0;
	int rx_mode = 0;
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		if (rx_phase % 200 == 0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0: m_tready <= 1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= (rx_phase % 7) < 3;
			default: m_tready <= ($urandom_range(0, 1) == 1);
		endcase
	end

	// monitor
	always @(posedge clk) begin
		point_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected word %h %b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				e = expected_points.pop_front();
				checked++;
				n_dz += e.dz;
				n_ovf += e.ovf;
				if (m_tdata[31:0] !== e.x || m_tdata[63:32] !== e.y ||
						m_tdata[95:64] !== e.z || m_tuser[0] !== e.dz ||
						m_tuser[1] !== e.ovf) begin
					$display("%0t: mismatch expected x=%h y=%h z=%h dz=%b ovf=%b",
						$time, e.x, e.y, e.z, e.dz, e.ovf);
					$display("%0t:          actual   x=%h y=%h z=%h dz=%b ovf=%b",
						$time, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
						m_tuser[0], m_tuser[1]);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
			3: return 32'(1 << 16);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] rand_entry();
		case ($urandom_range(0, 6))
			0: return 32'(1 << 16);
			1: return 32'h0;
			2: return 32'(signed'($urandom_range(0, 4 << 16)) - (2 << 16));
			3: return 32'h8000_0000;
			4: return 32'h7fff_ffff;
			default: return $urandom();
		endcase
	endfunction

	task automatic write_reg(int idx, logic [hpt_pkg::REGW-1:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= hpt_pkg::IDXW'(idx);
		cfg_data <= val;
		matrix[idx] = val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic load_matrix(int kind);
		for (int i = 0; i < hpt_pkg::NREG; i++) begin
			case (kind)
				0: write_reg(i, {rand_entry(), rand_entry()});
				1: write_reg(i, '1);
				2: write_reg(i, {32'h7fff_ffff, 32'h8000_0000});
				// identity
				3: write_reg(i, (i == 0 || i == 5) ? 64'h1_0000
					: ((i == 2 || i == 7) ? 64'h1_0000_0000_0000 : 64'h0));
				default: write_reg(i, {$urandom(), $urandom()});
			endcase
		end
	endtask

	task automatic drain();
		stream_on = 1;
		wait (pending_points.size() == 0 && expected_points.size() == 0);
		@(posedge clk);
		stream_on = 0;
		repeat (60) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < hpt_pkg::NREG; i++)
			matrix[i] = '0;
		matrix[7] = hpt_pkg::ROW3_23_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		// directed on reset matrix: only w survives, so x, y and z come out zero, with zero-w cases
		pending_points.push_back({32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
		pending_points.push_back({32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
		pending_points.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		pending_points.push_back({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
		pending_points.push_back('0);
		drain();
		load_matrix(3);
		pending_points.push_back({32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001});
		pending_points.push_back({32'h0000_0000, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000});
		pending_points.push_back({32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000});
		pending_points.push_back({32'hffff_ffff, 32'h0003_0000, 32'hfffd_0000, 32'h0000_0007});
		pending_points.push_back({32'h8000_0000, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000});
		pending_points.push_back({32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000});
		drain();
		load_matrix(1);
		pending_points.push_back({32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
		pending_points.push_back({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
		drain();
		load_matrix(2);
		pending_points.push_back({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
		pending_points.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			load_matrix(ph % 2 == 0 ? 0 : (ph == 3 ? 3 : 4));
			for (int k = 0; k < 100; k++)
				pending_points.push_back({rand_coord(), rand_coord(), rand_coord(), rand_coord()});
			drain();
		end
		$display("transformed %0d points over several matrices, %0d zero-w, %0d saturated",
			checked, n_dz, n_ovf);
		if (errors == 0 && expected_points.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
